// ===== src/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared sizes, codes and command types for the keyed reference count table.
// ----------------------------------------------------------------------------
package krt_pkg;

    // table geometry
    localparam int ENTRIES      = 16;
    localparam int COUNT_BITS   = 16;
    localparam int CONTEXT_BITS = 32;
    localparam int IDX_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // fixed port widths
    localparam int KEY_BITS      = 64;
    localparam int OUT_CNT_BITS  = 16;
    localparam int OUT_CTX_BITS  = 32;
    localparam int IN_CTX_BITS   = 32;

    // key value rejected out of reset
    localparam logic [KEY_BITS-1:0] REJECT_KEY_RST = {KEY_BITS{1'b1}};

    typedef logic [IDX_BITS-1:0] t_idx;

    // request kinds
    typedef enum logic [1:0] {
        REQ_INC      = 2'd0,
        REQ_DEC      = 2'd1,
        REQ_SET_RMV  = 2'd2,
        REQ_SET_NTFY = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_INVALID   = 3'd1,
        STS_FULL      = 3'd2,
        STS_MISSING   = 3'd3,
        STS_UNDERFLOW = 3'd4
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOOKUP = 2'd1,
        S_EXEC   = 2'd2
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // latch the request fields
        logic lookup;   // register key match and free slot search
        logic exec;     // read-modify-write of the chosen slot
    } t_ctrl_cmd;

endpackage

// ===== src/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl
// Sequencer: accept a request, run lookup, then the slot update.
// ----------------------------------------------------------------------------
module krt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output krt_pkg::t_ctrl_cmd o_cmd
);
    import krt_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: n_state = S_EXEC;
            S_EXEC:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        busy         = (r_state != S_IDLE);
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.lookup = (r_state == S_LOOKUP);
        o_cmd.exec   = (r_state == S_EXEC);
    end

    // a lookup is always followed by the update, and the update by idle
    a_lookup_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |=> o_cmd.exec)
        else $error("lookup not followed by update");
    a_exec_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !busy)
        else $error("update not followed by idle");
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_cmd.lookup)
        else $error("accepted request did not enter lookup");

endmodule

// ===== src/krt_datapath.sv =====
// ----------------------------------------------------------------------------
// krt_datapath
// Slot storage, key match, free slot search, slot update and result register.
// ----------------------------------------------------------------------------
module krt_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  krt_pkg::t_ctrl_cmd                 i_cmd,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [krt_pkg::KEY_BITS-1:0]       i_cfg_data,
    input  logic [1:0]                         i_req_type,
    input  logic [krt_pkg::KEY_BITS-1:0]       i_guid,
    input  logic [krt_pkg::IN_CTX_BITS-1:0]    i_context_handle,
    input  logic                               i_callback_enable,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [krt_pkg::OUT_CNT_BITS-1:0]   o_count_after,
    output logic                               o_removed,
    output logic                               o_notify,
    output logic [krt_pkg::OUT_CTX_BITS-1:0]   o_notify_context
);
    import krt_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // lowest set bit of a slot vector
    function automatic t_idx first_set(input logic [ENTRIES-1:0] v);
        t_idx idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_BITS'(i);
            end
        end
        return idx;
    endfunction

    // slot storage
    logic [ENTRIES-1:0]      r_slot_valid;
    logic [KEY_BITS-1:0]     r_slot_key    [ENTRIES];
    logic [COUNT_BITS-1:0]   r_slot_count  [ENTRIES];
    logic                    r_slot_mark   [ENTRIES];
    logic                    r_slot_armed  [ENTRIES];
    logic [CONTEXT_BITS-1:0] r_slot_ctx    [ENTRIES];

    // config register
    logic [KEY_BITS-1:0] r_invalid_key;

    // latched request
    t_req                    r_req_type;
    logic [KEY_BITS-1:0]     r_guid;
    logic [CONTEXT_BITS-1:0] r_ctx;
    logic                    r_en;

    // lookup results
    logic r_is_invalid;
    logic r_hit;
    logic r_has_free;
    t_idx r_hit_idx;
    t_idx r_free_idx;

    // result register
    logic                    r_done;
    t_status                 r_status;
    logic [COUNT_BITS-1:0]   r_res_count;
    logic                    r_removed;
    logic                    r_notify;
    logic [CONTEXT_BITS-1:0] r_res_ctx;

    // configuration write, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_key <= REJECT_KEY_RST;
        end else if (i_cfg_valid) begin
            r_invalid_key <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= t_req'(i_req_type);
            r_guid     <= i_guid;
            r_ctx      <= CONTEXT_BITS'(i_context_handle);
            r_en       <= i_callback_enable;
        end
    end

    // key match against every slot
    logic [ENTRIES-1:0] w_match;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_slot_valid[i] && (r_slot_key[i] == r_guid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_is_invalid <= (r_guid == r_invalid_key);
            r_hit        <= |w_match;
            r_has_free   <= ~&r_slot_valid;
            r_hit_idx    <= first_set(w_match);
            r_free_idx   <= first_set(~r_slot_valid);
        end
    end

    // slot update decision
    t_idx                    w_idx;
    logic [COUNT_BITS-1:0]   w_cur_count;
    logic                    w_cur_mark;
    logic                    w_cur_armed;
    logic [CONTEXT_BITS-1:0] w_cur_ctx;
    logic                    w_wr;
    logic                    w_free_slot;
    logic [COUNT_BITS-1:0]   w_new_count;
    logic                    w_new_mark;
    logic                    w_new_armed;
    logic [CONTEXT_BITS-1:0] w_new_ctx;
    t_status                 w_status;
    logic [COUNT_BITS-1:0]   w_res_count;
    logic                    w_removed;
    logic                    w_notify;
    logic [CONTEXT_BITS-1:0] w_res_ctx;
    logic [COUNT_BITS-1:0]   w_dec_count;

    always_comb begin
        w_idx = r_hit ? r_hit_idx : r_free_idx;
        // a freshly allocated slot starts from cleared fields
        w_cur_count = r_hit ? r_slot_count[w_idx] : '0;
        w_cur_mark  = r_hit ? r_slot_mark[w_idx]  : 1'b0;
        w_cur_armed = r_hit ? r_slot_armed[w_idx] : 1'b0;
        w_cur_ctx   = r_hit ? r_slot_ctx[w_idx]   : '0;
        w_dec_count = COUNT_BITS'(w_cur_count - 1'b1);

        w_wr        = 1'b0;
        w_free_slot = 1'b0;
        w_new_count = w_cur_count;
        w_new_mark  = w_cur_mark;
        w_new_armed = w_cur_armed;
        w_new_ctx   = w_cur_ctx;
        w_status    = STS_OK;
        w_res_count = '0;
        w_removed   = 1'b0;
        w_notify    = 1'b0;
        w_res_ctx   = '0;

        if (r_is_invalid) begin
            w_status = STS_INVALID;
        end else begin
            unique case (r_req_type)
                REQ_INC: begin
                    if (!r_hit && !r_has_free) begin
                        w_status = STS_FULL;
                    end else begin
                        w_wr = 1'b1;
                        // saturate at the top count
                        if (w_cur_count != COUNT_MAX) begin
                            w_new_count = COUNT_BITS'(w_cur_count + 1'b1);
                        end
                        w_res_count = w_new_count;
                    end
                end
                REQ_DEC: begin
                    if (!r_hit) begin
                        w_status = STS_MISSING;
                    end else if (w_cur_count == '0) begin
                        w_status = STS_UNDERFLOW;
                    end else begin
                        w_wr        = 1'b1;
                        w_new_count = w_dec_count;
                        w_res_count = w_dec_count;
                        if (w_dec_count == '0) begin
                            if (w_cur_armed) begin
                                w_notify  = 1'b1;
                                w_res_ctx = w_cur_ctx;
                            end
                            if (w_cur_mark) begin
                                w_free_slot = 1'b1;
                                w_removed   = 1'b1;
                            end
                        end
                    end
                end
                REQ_SET_RMV: begin
                    if (!r_hit) begin
                        w_status = STS_MISSING;
                    end else if (w_cur_count == '0) begin
                        w_wr        = 1'b1;
                        w_free_slot = 1'b1;
                        w_removed   = 1'b1;
                    end else begin
                        w_wr        = 1'b1;
                        w_new_mark  = 1'b1;
                        w_res_count = w_cur_count;
                    end
                end
                REQ_SET_NTFY: begin
                    if (!r_hit && !r_has_free) begin
                        w_status = STS_FULL;
                    end else begin
                        w_wr        = 1'b1;
                        w_new_ctx   = r_ctx;
                        w_new_armed = r_en;
                        w_res_count = w_cur_count;
                        if ((w_cur_count == '0) && r_en) begin
                            w_notify  = 1'b1;
                            w_res_ctx = r_ctx;
                        end
                    end
                end
                default: begin
                    w_status = STS_OK;
                end
            endcase
        end
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (i_cmd.exec && w_wr) begin
            r_slot_valid[w_idx] <= !w_free_slot;
        end
    end

    // slot payload write
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr) begin
            r_slot_key[w_idx]   <= r_guid;
            r_slot_count[w_idx] <= w_new_count;
            r_slot_mark[w_idx]  <= w_new_mark;
            r_slot_armed[w_idx] <= w_new_armed;
            r_slot_ctx[w_idx]   <= w_new_ctx;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= w_status;
            r_res_count <= w_res_count;
            r_removed   <= w_removed;
            r_notify    <= w_notify;
            r_res_ctx   <= w_res_ctx;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_count_after    = OUT_CNT_BITS'(r_res_count);
    assign o_removed        = r_removed;
    assign o_notify         = r_notify;
    assign o_notify_context = OUT_CTX_BITS'(r_res_ctx);

    // a result only follows an update cycle
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_cmd.exec))
        else $error("result strobe without update");
    // error results carry no count, removal or notification
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STS_OK))
            |-> (o_count_after == '0) && !o_removed && !o_notify)
        else $error("error result with side fields set");
    // a freed entry reports a zero count
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_removed) |-> (o_count_after == '0) && (o_status == STS_OK))
        else $error("removed entry with nonzero count");
    // the rejected key never lands in a slot
    a_invalid_not_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_is_invalid) |-> !w_wr)
        else $error("invalid key written to table");

endmodule

// ===== src/keyed_refcount_table.sv =====
// ----------------------------------------------------------------------------
// keyed_refcount_table
// Outstanding-operation counters keyed by a 64-bit id, 16 slots.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req_type, i_guid, i_context_handle and
//   i_callback_enable with start high; the request is taken at the clock
//   edge where start is high and busy is low. busy stays high for the
//   lookup and update cycles that follow.
//   Result channel: o_done is high for exactly one cycle with o_status,
//   o_count_after, o_removed, o_notify and o_notify_context valid. The
//   receiver cannot stall; it must take the result in that cycle.
//   Sequence: the request is captured at the accepting edge, the parallel
//   key match plus free slot search is registered in the lookup state,
//   and the chosen slot is written as the update state ends, as o_done rises.
//   Requests do not overlap: busy holds off a new one during the match
//   and the single read-modify-write of the chosen slot; a new request
//   may be taken in the cycle the previous result is shown.
//   Config: i_cfg_valid / o_cfg_ready write i_cfg_data as the invalid key;
//   write only while idle.
//   Reset (synchronous, i_rst_n low): all slots empty, invalid key all
//   ones, no result pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_refcount_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_req_type,
    input  logic [krt_pkg::KEY_BITS-1:0]     i_guid,
    input  logic [krt_pkg::IN_CTX_BITS-1:0]  i_context_handle,
    input  logic                             i_callback_enable,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [krt_pkg::KEY_BITS-1:0]     i_cfg_data,
    output logic                             o_done,
    output logic [2:0]                       o_status,
    output logic [krt_pkg::OUT_CNT_BITS-1:0] o_count_after,
    output logic                             o_removed,
    output logic                             o_notify,
    output logic [krt_pkg::OUT_CTX_BITS-1:0] o_notify_context
);
    import krt_pkg::*;

    t_ctrl_cmd w_cmd;

    // sequencer
    krt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // table and update logic
    krt_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_guid            (i_guid),
        .i_context_handle  (i_context_handle),
        .i_callback_enable (i_callback_enable),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_count_after     (o_count_after),
        .o_removed         (o_removed),
        .o_notify          (o_notify),
        .o_notify_context  (o_notify_context)
    );

endmodule
